// ===== rtl/core/rsi_pkg.sv =====
// Shared types and constants of the ray/sphere intersection core.
// No dependencies; the core top, rsi_front and rsi_back import this package.
`default_nettype none

package rsi_pkg;

	// Number of coordinate axes handled in parallel lanes
	localparam int NUM_AXES = 3;

	// Configuration register indexes
	localparam logic [2:0] CFG_CENTER_X = 3'd0;
	localparam logic [2:0] CFG_CENTER_Y = 3'd1;
	localparam logic [2:0] CFG_CENTER_Z = 3'd2;
	localparam logic [2:0] CFG_RADIUS   = 3'd3;

	// Smallest discriminant that counts as a hit (1e-4 in Q16.16, rounded up)
	localparam int DISCR_MIN = 7;
	// 1.0 in Q16.16, also the normal saturation limit
	localparam int ONE_Q16 = 65536;

	// Classified ray as it travels from the front end to the back end
	typedef struct packed {
		logic [2:0][31:0] org;
		logic [2:0][17:0] dir;
		logic [37:0]      b;
		logic [57:0]      d;
		logic             miss;
	} mid_item_t;

	// Finished result item
	typedef struct packed {
		logic             hit;
		logic [30:0]      distance;
		logic [2:0][31:0] pt;
		logic [2:0][17:0] nrm;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/ray_sphere_intersect_core.sv =====
// Ray/sphere intersection core: configuration registers, queues and the two pipeline halves.
// Depends on rsi_pkg, rsi_fifo, rsi_front and rsi_back.
//
// Usage:
//   Rays enter through push/full: a ray is taken at a clock edge with push high and
//   full low. Results leave through empty/pop: the oldest result sits on the result
//   ports while empty is low and is taken at an edge with pop high. One result per ray,
//   in ray order; a miss gives hit = 0 and all other fields zero.
//   Sphere center and radius are written on the cfg channel (cfg_ready is always high);
//   write them only while no ray is in flight. Unknown indexes are ignored.
// Timing:
//   One ray per cycle sustained while results are popped. The accepting edge loads the
//   first of six front stages; the item then passes the middle queue, 37 square-root
//   stages (one root bit each), three distance and hit-point stages, 17 normal-division
//   stages and the output queue write. When pop stays low the back end holds, the middle
//   queue fills, then the front end holds and full rises; no item is lost.
// Reset:
//   arst_n clears all pipeline valids and queues and loads center 0, radius 1.0.
`default_nettype none

module ray_sphere_intersect_core
	import rsi_pkg::*;
#(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] ray_origin_x,
	input  logic signed [31:0] ray_origin_y,
	input  logic signed [31:0] ray_origin_z,
	input  logic signed [17:0] ray_dir_x,
	input  logic signed [17:0] ray_dir_y,
	input  logic signed [17:0] ray_dir_z,
	output logic               empty,
	input  logic               pop,
	output logic               hit,
	output logic [30:0]        hit_distance,
	output logic signed [31:0] hit_point_x,
	output logic signed [31:0] hit_point_y,
	output logic signed [31:0] hit_point_z,
	output logic signed [17:0] surface_normal_x,
	output logic signed [17:0] surface_normal_y,
	output logic signed [17:0] surface_normal_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [2:0][31:0] ctr_q;
	logic [30:0]      rad_q, r_eff;
	logic [45:0]      rsq_q;
	logic [61:0]      rr_c;

	mid_item_t mid_in, mid_out;
	out_item_t out_in, out_out;
	logic      mid_push, mid_pop, mid_full, mid_empty;
	logic      out_push, out_full;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			rad_q <= 31'(ONE_Q16);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CENTER_X: ctr_q[0] <= cfg_data;
				CFG_CENTER_Y: ctr_q[1] <= cfg_data;
				CFG_CENTER_Z: ctr_q[2] <= cfg_data;
				CFG_RADIUS:   rad_q    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Zero radius acts as the smallest radius; precompute r^2 in Q16.16
	assign r_eff = (rad_q == '0) ? 31'd1 : rad_q;
	assign rr_c  = 62'(r_eff) * 62'(r_eff);

	always_ff @(posedge clk) begin
		rsq_q <= rr_c[61:16];
	end

	rsi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.org      ({ray_origin_z, ray_origin_y, ray_origin_x}),
		.dir      ({ray_dir_z, ray_dir_y, ray_dir_x}),
		.ctr      (ctr_q),
		.rsq      (rsq_q),
		.mid_full (mid_full),
		.mid_push (mid_push),
		.mid_item (mid_in)
	);

	rsi_fifo #(
		.W     ($bits(mid_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.pop    (mid_pop),
		.din    (mid_in),
		.dout   (mid_out),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	rsi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_item  (mid_out),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.ctr       (ctr_q),
		.rad       (r_eff),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_in)
	);

	rsi_fifo #(
		.W     ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.pop    (pop),
		.din    (out_in),
		.dout   (out_out),
		.full   (out_full),
		.empty  (empty)
	);

	// Drive result ports from the queue head
	assign hit              = out_out.hit;
	assign hit_distance     = out_out.distance;
	assign hit_point_x      = out_out.pt[0];
	assign hit_point_y      = out_out.pt[1];
	assign hit_point_z      = out_out.pt[2];
	assign surface_normal_x = out_out.nrm[0];
	assign surface_normal_y = out_out.nrm[1];
	assign surface_normal_z = out_out.nrm[2];

endmodule

`default_nettype wire

// ===== rtl/core/rsi_fifo.sv =====
// Small register-based queue used between the front and back ends and at the output.
// Depends on nothing; width and depth come from parameters.
`default_nettype none

module rsi_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic         pop,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count beyond depth");

	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !(pop && !empty)) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not grow on push");

	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && dout == $past(dout)))
		else $error("queue head changed without pop");

endmodule

`default_nettype wire

// ===== rtl/core/rsi_front.sv =====
// Front end: accepts rays, forms m, b, c and the discriminant, and marks misses.
// Depends on rsi_pkg; feeds the middle queue.
`default_nettype none

module rsi_front
	import rsi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [2:0][31:0] org,
	input  logic [2:0][17:0] dir,
	input  logic [2:0][31:0] ctr,
	input  logic [45:0]      rsq,
	input  logic             mid_full,
	output logic             mid_push,
	output mid_item_t        mid_item
);

	logic [5:0] v_q;
	logic       adv;

	logic [2:0][31:0] org_s1, org_s2, org_s3, org_s4, org_s5;
	logic [2:0][17:0] dir_s1, dir_s2, dir_s3, dir_s4, dir_s5;
	logic signed [32:0] m_s2 [NUM_AXES];
	logic signed [50:0] md_s3 [NUM_AXES];
	logic [49:0]        sq_s3 [NUM_AXES];
	logic signed [37:0] b_s4, b_s5;
	logic signed [52:0] c_s4, c_s5;
	logic               miss0_s5;
	logic [43:0]        hh_s5;
	logic [37:0]        hl_s5;
	logic [31:0]        ll_s5;

	logic [32:0]        abs_c [NUM_AXES];
	logic [65:0]        sqp_c [NUM_AXES];
	logic signed [52:0] dot_c;
	logic [51:0]        sumsq_c;
	logic [37:0]        babs_c;
	logic [59:0]        bsq_c;
	logic signed [61:0] c4_c, discr_c;

	// Stall the whole front end only when its last stage cannot drain
	assign adv      = !v_q[5] || !mid_full;
	assign full     = !adv;
	assign mid_push = v_q[5] && !mid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[4:0], push};
		end
	end

	// Per-stage arithmetic
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			abs_c[i] = m_s2[i][32] ? 33'(-m_s2[i]) : 33'(m_s2[i]);
			sqp_c[i] = 66'(abs_c[i]) * 66'(abs_c[i]);
		end
		dot_c   = 53'(md_s3[0]) + 53'(md_s3[1]) + 53'(md_s3[2]);
		sumsq_c = 52'(sq_s3[0]) + 52'(sq_s3[1]) + 52'(sq_s3[2]);
		babs_c  = b_s4[37] ? 38'(-b_s4) : 38'(b_s4);
		bsq_c   = {hh_s5, 16'b0} + 60'({hl_s5, 1'b0}) + 60'(ll_s5[31:16]);
		c4_c    = 62'(c_s5) <<< 2;
		discr_c = $signed({2'b0, bsq_c}) - c4_c;
	end

	// Advance the pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			org_s1 <= org;
			dir_s1 <= dir;

			org_s2 <= org_s1;
			dir_s2 <= dir_s1;
			for (int i = 0; i < NUM_AXES; i++) begin
				m_s2[i] <= 33'($signed(org_s1[i])) - 33'($signed(ctr[i]));
			end

			org_s3 <= org_s2;
			dir_s3 <= dir_s2;
			for (int i = 0; i < NUM_AXES; i++) begin
				md_s3[i] <= m_s2[i] * $signed(dir_s2[i]);
				sq_s3[i] <= sqp_c[i][65:16];
			end

			org_s4 <= org_s3;
			dir_s4 <= dir_s3;
			b_s4   <= dot_c[52:15];
			c_s4   <= $signed({1'b0, sumsq_c}) - $signed(53'(rsq));

			org_s5   <= org_s4;
			dir_s5   <= dir_s4;
			b_s5     <= b_s4;
			c_s5     <= c_s4;
			miss0_s5 <= (c_s4 > 0) && (b_s4 > 0);
			hh_s5    <= 44'(babs_c[37:16]) * 44'(babs_c[37:16]);
			hl_s5    <= 38'(babs_c[37:16]) * 38'(babs_c[15:0]);
			ll_s5    <= 32'(babs_c[15:0]) * 32'(babs_c[15:0]);

			mid_item.org  <= org_s5;
			mid_item.dir  <= dir_s5;
			mid_item.b    <= b_s5;
			mid_item.d    <= discr_c[57:0];
			mid_item.miss <= miss0_s5 || (discr_c < $signed(62'(DISCR_MIN)));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rsi_back.sv =====
// Back end: square root, distance, hit point and normal division pipeline.
// Depends on rsi_pkg; drains the middle queue and fills the output queue.
`default_nettype none

module rsi_back
	import rsi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mid_item_t        mid_item,
	input  logic             mid_empty,
	output logic             mid_pop,
	input  logic [2:0][31:0] ctr,
	input  logic [30:0]      rad,
	input  logic             out_full,
	output logic             out_push,
	output out_item_t        out_item
);

	localparam int SQ_N   = 37;
	localparam int ROOT_W = 37;
	localparam int REM_W  = 40;
	localparam int DIV_N  = 16;
	localparam int LAST   = SQ_N + 3 + DIV_N;

	typedef struct packed {
		logic             miss;
		logic [30:0]      t;
		logic [2:0][31:0] pt;
	} post_t;

	logic [LAST:0] vld_q;
	logic          adv;

	mid_item_t         it_s [SQ_N];
	mid_item_t         it_in [SQ_N];
	logic [ROOT_W-1:0] root_s [SQ_N], root_in [SQ_N], root_n [SQ_N];
	logic [REM_W-1:0]  rem_s [SQ_N], rem_in [SQ_N], rem_n [SQ_N];

	logic [30:0]        t_s37, t_s38, t_s39;
	logic [2:0][31:0]   org_s37, org_s38;
	logic [2:0][17:0]   dir_s37;
	logic               miss_s37, miss_s38, miss_s39;
	logic signed [49:0] prod_s38 [NUM_AXES];
	logic [2:0][31:0]   pt_s39;

	post_t       dpost_s [DIV_N+1];
	logic [30:0] drem_s [DIV_N+1][NUM_AXES];
	logic [16:0] dq_s [DIV_N+1][NUM_AXES];
	logic        dneg_s [DIV_N+1][NUM_AXES];
	logic        dovf_s [DIV_N+1][NUM_AXES];

	logic signed [39:0] bx_c, n_c;
	logic [38:0]        h_c;
	logic [30:0]        t_c;
	logic signed [34:0] sum_c [NUM_AXES];
	logic [31:0]        pt_c [NUM_AXES];
	logic signed [32:0] diff_c [NUM_AXES];
	logic [32:0]        mag_c [NUM_AXES];
	logic               qb_c [NUM_AXES];
	logic [32:0]        rem0_c [NUM_AXES];

	// Hold everything while the finished item cannot leave
	assign adv      = !vld_q[LAST] || !out_full;
	assign mid_pop  = adv && !mid_empty;
	assign out_push = vld_q[LAST] && !out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAST-1:0], mid_pop};
		end
	end

	// Square root, one result bit per stage
	always_comb begin
		logic [REM_W-1:0] sh, tr;
		logic [1:0]       pr;
		it_in[0]   = mid_item;
		root_in[0] = '0;
		rem_in[0]  = '0;
		for (int i = 1; i < SQ_N; i++) begin
			it_in[i]   = it_s[i-1];
			root_in[i] = root_s[i-1];
			rem_in[i]  = rem_s[i-1];
		end
		for (int i = 0; i < SQ_N; i++) begin
			pr = 2'b00;
			if (SQ_N - 1 - i >= 8) begin
				pr = 2'(it_in[i].d >> (2 * (SQ_N - 1 - i) - 16));
			end
			sh = {rem_in[i][REM_W-3:0], pr};
			tr = {1'b0, root_in[i], 2'b01};
			if (sh >= tr) begin
				rem_n[i]  = sh - tr;
				root_n[i] = {root_in[i][ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[i]  = sh;
				root_n[i] = {root_in[i][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < SQ_N; i++) begin
				it_s[i]   <= it_in[i];
				root_s[i] <= root_n[i];
				rem_s[i]  <= rem_n[i];
			end
		end
	end

	// Distance, hit point and first division step
	always_comb begin
		bx_c = 40'($signed(it_s[SQ_N-1].b));
		n_c  = -bx_c - $signed(40'(root_s[SQ_N-1]));
		h_c  = n_c[39:1];
		if (n_c < 0) begin
			t_c = '0;
		end else if (|h_c[38:31]) begin
			t_c = 31'h7FFF_FFFF;
		end else begin
			t_c = h_c[30:0];
		end
		for (int i = 0; i < NUM_AXES; i++) begin
			sum_c[i] = 35'($signed(org_s38[i])) + 35'($signed(prod_s38[i][49:16]));
			if (sum_c[i] > $signed(35'h0_7FFF_FFFF)) begin
				pt_c[i] = 32'h7FFF_FFFF;
			end else if (sum_c[i] < -$signed(35'h0_8000_0000)) begin
				pt_c[i] = 32'h8000_0000;
			end else begin
				pt_c[i] = sum_c[i][31:0];
			end
			diff_c[i] = 33'($signed(pt_s39[i])) - 33'($signed(ctr[i]));
			mag_c[i]  = diff_c[i][32] ? 33'(-diff_c[i]) : 33'(diff_c[i]);
			qb_c[i]   = mag_c[i] >= {2'b0, rad};
			rem0_c[i] = qb_c[i] ? mag_c[i] - {2'b0, rad} : mag_c[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s37    <= t_c;
			org_s37  <= it_s[SQ_N-1].org;
			dir_s37  <= it_s[SQ_N-1].dir;
			miss_s37 <= it_s[SQ_N-1].miss;

			t_s38    <= t_s37;
			org_s38  <= org_s37;
			miss_s38 <= miss_s37;
			for (int i = 0; i < NUM_AXES; i++) begin
				prod_s38[i] <= $signed({1'b0, t_s37}) * $signed(dir_s37[i]);
			end

			t_s39    <= t_s38;
			miss_s39 <= miss_s38;
			for (int i = 0; i < NUM_AXES; i++) begin
				pt_s39[i] <= pt_c[i];
			end

			dpost_s[0].miss <= miss_s39;
			dpost_s[0].t    <= t_s39;
			dpost_s[0].pt   <= pt_s39;
			for (int i = 0; i < NUM_AXES; i++) begin
				drem_s[0][i] <= rem0_c[i][30:0];
				dq_s[0][i]   <= {16'b0, qb_c[i]};
				dneg_s[0][i] <= diff_c[i][32];
				dovf_s[0][i] <= {1'b0, mag_c[i]} >= {2'b0, rad, 1'b0};
			end
		end
	end

	// Remaining normal division steps, one quotient bit each
	always_ff @(posedge clk) begin
		logic [31:0] sh2;
		if (adv) begin
			for (int j = 1; j <= DIV_N; j++) begin
				dpost_s[j] <= dpost_s[j-1];
				for (int i = 0; i < NUM_AXES; i++) begin
					sh2 = {drem_s[j-1][i], 1'b0};
					dneg_s[j][i] <= dneg_s[j-1][i];
					dovf_s[j][i] <= dovf_s[j-1][i];
					if (sh2 >= {1'b0, rad}) begin
						drem_s[j][i] <= 31'(sh2 - {1'b0, rad});
						dq_s[j][i]   <= {dq_s[j-1][i][15:0], 1'b1};
					end else begin
						drem_s[j][i] <= sh2[30:0];
						dq_s[j][i]   <= {dq_s[j-1][i][15:0], 1'b0};
					end
				end
			end
		end
	end

	// Clamp the normal and blank the fields of a miss
	always_comb begin
		logic [16:0] nm;
		out_item.hit      = !dpost_s[DIV_N].miss;
		out_item.distance = dpost_s[DIV_N].miss ? '0 : dpost_s[DIV_N].t;
		for (int i = 0; i < NUM_AXES; i++) begin
			if (dovf_s[DIV_N][i] || dq_s[DIV_N][i] > 17'(ONE_Q16)) begin
				nm = 17'(ONE_Q16);
			end else begin
				nm = dq_s[DIV_N][i];
			end
			if (dpost_s[DIV_N].miss) begin
				out_item.pt[i]  = '0;
				out_item.nrm[i] = '0;
			end else begin
				out_item.pt[i]  = dpost_s[DIV_N].pt[i];
				out_item.nrm[i] = dneg_s[DIV_N][i] ? 18'(-$signed({1'b0, nm})) : {1'b0, nm};
			end
		end
	end

endmodule

`default_nettype wire
